[hdl/cis_pkg.sv]
// Shared types and constants for the cached interval search block.
// No dependencies; imported by cis_ctrl, cis_datapath and the top level.
package cis_pkg;

	localparam int CNT_W  = 11;  // sample count, cache and result index
	localparam int IDX_W  = 10;  // write_index port width
	localparam int TIME_W = 64;  // Q31.32 signed time

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_CK_LO,
		ST_CK_HI,
		ST_SEARCH,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		ADDR_CACHE_LO,
		ADDR_CACHE_HI,
		ADDR_SRCH_INIT,
		ADDR_SRCH_NEXT
	} addr_sel_t;

	typedef struct packed {
		logic      latch;      // capture the accepted transaction
		logic      mem_wr;     // store time_value into the table
		addr_sel_t addr_sel;   // table read address source
		logic      srch_init;  // lo = 0, len = count
		logic      srch_step;  // one lower-bound step
		logic      hit_load;   // lo = cached index
		logic      load_out;   // result to output register, update cache
	} cmd_t;

	typedef struct packed {
		logic in_op;          // op of the offered transaction
		logic cache_ok;       // 1 <= cache < count
		logic count_zero;     // effective count is zero
		logic t_lt_data;      // query time below read entry
		logic t_gt_data;      // query time above read entry
		logic len_next_zero;  // search ends after this step
	} sts_t;

endpackage

[hdl/cis_ctrl.sv]
// Controller for the cached interval search: sequencing FSM and output valid.
// Depends on cis_pkg; drives cis_datapath through cmd_t, reads sts_t.
module cis_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  cis_pkg::sts_t  sts,
	output cis_pkg::cmd_t  cmd
);
	import cis_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt    = state_q;
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.addr_sel = ADDR_SRCH_INIT;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					if (sts.in_op == OP_WRITE) begin
						cmd.mem_wr = 1'b1;
					end else begin
						state_nxt = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				if (sts.cache_ok) begin
					cmd.addr_sel = ADDR_CACHE_LO;
					state_nxt    = ST_CK_LO;
				end else begin
					cmd.srch_init = 1'b1;
					state_nxt     = sts.count_zero ? ST_FINISH : ST_SEARCH;
				end
			end
			ST_CK_LO: begin
				if (sts.t_lt_data) begin
					cmd.srch_init = 1'b1;
					state_nxt     = sts.count_zero ? ST_FINISH : ST_SEARCH;
				end else begin
					cmd.addr_sel = ADDR_CACHE_HI;
					state_nxt    = ST_CK_HI;
				end
			end
			ST_CK_HI: begin
				if (sts.t_gt_data) begin
					cmd.srch_init = 1'b1;
					state_nxt     = sts.count_zero ? ST_FINISH : ST_SEARCH;
				end else begin
					cmd.hit_load = 1'b1;
					state_nxt    = ST_FINISH;
				end
			end
			ST_SEARCH: begin
				cmd.srch_step = 1'b1;
				cmd.addr_sel  = ADDR_SRCH_NEXT;
				if (sts.len_next_zero) begin
					state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

[hdl/cis_datapath.sv]
// Datapath for the cached interval search: time table, count register,
// cache, search window and result register. Depends on cis_pkg.
module cis_datapath #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  cis_pkg::cmd_t                      cmd,
	output cis_pkg::sts_t                      sts,
	input  logic                               cfg_wr_en,
	input  logic [cis_pkg::CNT_W-1:0]          cfg_wr_data,
	input  logic                               op,
	input  logic [cis_pkg::IDX_W-1:0]          write_index,
	input  logic signed [cis_pkg::TIME_W-1:0]  time_value,
	output logic [cis_pkg::CNT_W-1:0]          sample_index
);
	import cis_pkg::*;

	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

	logic [TIME_W-1:0]        mem [MAX_SAMPLES];
	logic signed [TIME_W-1:0] rdata_q;
	logic signed [TIME_W-1:0] t_q;
	logic [CNT_W-1:0]         cfg_q;
	logic [CNT_W-1:0]         cache_q;
	logic [CNT_W-1:0]         lo_q, len_q;
	logic [CNT_W-1:0]         out_idx_q;

	logic [CNT_W-1:0] cnt_eff;
	logic [CNT_W-1:0] half, lo_up, len_up, addr_up, addr_dn, raddr;
	logic [31:0]      wr_ext, rd_ext;
	logic             wr_ok, t_gt;

	// effective count is capped at the table depth
	assign cnt_eff = (32'(cfg_q) > 32'(MAX_SAMPLES)) ? CNT_W'(MAX_SAMPLES) : cfg_q;

	assign half    = len_q >> 1;
	assign lo_up   = lo_q + half + CNT_W'(1);
	assign len_up  = len_q - half - CNT_W'(1);
	// both candidate next probes are ready before the compare resolves
	assign addr_up = lo_up + (len_up >> 1);
	assign addr_dn = lo_q + (half >> 1);
	assign t_gt    = t_q > rdata_q;

	always_comb begin
		case (cmd.addr_sel)
			ADDR_CACHE_LO:  raddr = cache_q - CNT_W'(1);
			ADDR_CACHE_HI:  raddr = cache_q;
			ADDR_SRCH_INIT: raddr = cnt_eff >> 1;
			ADDR_SRCH_NEXT: raddr = t_gt ? addr_up : addr_dn;
			default:        raddr = cnt_eff >> 1;
		endcase
	end

	assign wr_ext = 32'(write_index);
	assign rd_ext = 32'(raddr);
	assign wr_ok  = wr_ext < 32'(MAX_SAMPLES);

	always_ff @(posedge clk) begin
		if (cmd.mem_wr && wr_ok) begin
			mem[wr_ext[AW-1:0]] <= time_value;
		end
		rdata_q <= mem[rd_ext[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= '0;
			cache_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (cmd.load_out) begin
				cache_q <= lo_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			t_q <= time_value;
		end
		if (cmd.srch_init) begin
			lo_q  <= '0;
			len_q <= cnt_eff;
		end else if (cmd.hit_load) begin
			lo_q <= cache_q;
		end else if (cmd.srch_step) begin
			if (t_gt) begin
				lo_q  <= lo_up;
				len_q <= len_up;
			end else begin
				len_q <= half;
			end
		end
		if (cmd.load_out) begin
			out_idx_q <= lo_q;
		end
	end

	assign sample_index = out_idx_q;

	always_comb begin
		sts.in_op         = op;
		sts.cache_ok      = (cache_q != '0) && (cache_q < cnt_eff);
		sts.count_zero    = (cnt_eff == '0);
		sts.t_lt_data     = t_q < rdata_q;
		sts.t_gt_data     = t_gt;
		sts.len_next_zero = t_gt ? (len_up == '0) : (half == '0);
	end

endmodule

[hdl/cached_interval_search_top.sv]
// Top level of the cached interval search block.
// Depends on cis_pkg, cis_ctrl and cis_datapath.
//
// Keeps an ascending table of signed Q31.32 sample times (MAX_SAMPLES deep)
// and answers interval queries. A transaction with op = 0 stores time_value
// at write_index (indexes at or past MAX_SAMPLES are dropped) and produces no
// result; the FSM stays idle, so the next transaction can be accepted on the
// following edge. A transaction with op = 1 returns sample_index: the cached
// index n if 1 <= n < count and table[n-1] <= t <= table[n], otherwise the
// lower-bound index (first entry >= t, or count), which then becomes the new
// cached index. count is min(sample_count, MAX_SAMPLES), written through
// cfg_wr_en/cfg_wr_data; the user must write it only while no query is in
// flight, which the block does not enforce. Table entries must be written
// before a query can read them; the table is not cleared at reset.
// Sequencing: one query is in flight at a time. A cache hit holds the input
// side through its steps (accept, probe of table[n-1], probe of table[n],
// compare, result load). A miss runs the binary search at one table read per
// cycle on the single read port, floor(log2(count))+1 steps at most. The
// result sits in an output register, so the block goes back to accepting
// transactions while a result waits for out_ready; only a second query's
// result stalls behind it.
module cached_interval_search_top #(
	parameter int MAX_SAMPLES = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [cis_pkg::CNT_W-1:0]          cfg_wr_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               op,
	input  logic [cis_pkg::IDX_W-1:0]          write_index,
	input  logic signed [cis_pkg::TIME_W-1:0]  time_value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [cis_pkg::CNT_W-1:0]          sample_index
);
	import cis_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencing: idle/accept, cache probes, search steps, result handoff
	cis_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// table memory, count and cache registers, search window
	cis_datapath #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.op           (op),
		.write_index  (write_index),
		.time_value   (time_value),
		.sample_index (sample_index)
	);

endmodule
